// ----- design/ppc_instruction_encoder_unit_defines.svh -----
// Assertion macros shared by the instruction encoder modules.
// Needs nothing else; taken in by the files that carry assertions.
`ifndef PPC_INSTRUCTION_ENCODER_UNIT_DEFINES_SVH
`define PPC_INSTRUCTION_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, held off while in reset
`define PPCENC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppcenc assertion failed");

// next-cycle implication, held off while in reset
`define PPCENC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppcenc assertion failed");

`endif

// ----- design/ppcenc_pkg.sv -----
// Types, codes and the mnemonic table of the instruction encoder.
// No dependencies; used by every module of the encoder.
package ppcenc_pkg;

	localparam int unsigned CMD_COUNT = 42;

	localparam logic [2:0] KIND_REG  = 3'd1;
	localparam logic [2:0] KIND_NUM  = 3'd2;
	localparam logic [2:0] KIND_SIMM = 3'd3;
	localparam logic [2:0] KIND_UIMM = 3'd4;
	localparam logic [2:0] KIND_ADDR = 3'd5;

	typedef enum logic [2:0] {
		FORM_XO3,
		FORM_XO2,
		FORM_SWAP3,
		FORM_SIMM,
		FORM_UIMM,
		FORM_BLONG,
		FORM_BSHORT,
		FORM_BREG
	} form_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_BAD_KIND,
		ERR_VALUE_RANGE,
		ERR_PC_ALIGN,
		ERR_TARGET_ALIGN,
		ERR_BAD_ABSOLUTE,
		ERR_BRANCH_RANGE
	} err_t;

	typedef struct packed {
		form_t      form;
		logic [5:0] primary;
		logic [9:0] ext;
		logic       oe;
		logic       rclk;
		logic       aa;
	} enc_entry_t;

	typedef struct packed {
		logic [5:0]  command;
		logic [2:0]  kind_first;
		logic [2:0]  kind_second;
		logic [2:0]  kind_third;
		logic [4:0]  field_first;
		logic [4:0]  field_second;
		logic [4:0]  field_third;
		logic [31:0] imm_value;
		logic [31:0] cur_address;
	} in_item_t;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [2:0]  error_code;
	} out_item_t;

	// classified request handed from the front to the back
	typedef struct packed {
		enc_entry_t  entry;
		err_t        err;
		logic [4:0]  f0;
		logic [4:0]  f1;
		logic [4:0]  f2;
		logic [31:0] imm;
		logic [31:0] diff;
	} cls_item_t;

	typedef struct packed {
		logic full;
		logic head_valid;
	} q_status_t;

	localparam enc_entry_t ENC_TABLE [CMD_COUNT] = '{
		'{FORM_XO3, 6'd31, 10'd266, 1'b0, 1'b0, 1'b0},
		'{FORM_XO3, 6'd31, 10'd266, 1'b0, 1'b1, 1'b0},
		'{FORM_XO3, 6'd31, 10'd266, 1'b1, 1'b0, 1'b0},
		'{FORM_XO3, 6'd31, 10'd266, 1'b1, 1'b1, 1'b0},
		'{FORM_XO3, 6'd31, 10'd10, 1'b0, 1'b0, 1'b0},
		'{FORM_XO3, 6'd31, 10'd10, 1'b0, 1'b1, 1'b0},
		'{FORM_XO3, 6'd31, 10'd10, 1'b1, 1'b0, 1'b0},
		'{FORM_XO3, 6'd31, 10'd10, 1'b1, 1'b1, 1'b0},
		'{FORM_XO3, 6'd31, 10'd138, 1'b0, 1'b0, 1'b0},
		'{FORM_XO3, 6'd31, 10'd138, 1'b0, 1'b1, 1'b0},
		'{FORM_XO3, 6'd31, 10'd138, 1'b1, 1'b0, 1'b0},
		'{FORM_XO3, 6'd31, 10'd138, 1'b1, 1'b1, 1'b0},
		'{FORM_SIMM, 6'd14, 10'd0, 1'b0, 1'b0, 1'b0},
		'{FORM_SIMM, 6'd12, 10'd0, 1'b0, 1'b0, 1'b0},
		'{FORM_SIMM, 6'd13, 10'd0, 1'b0, 1'b0, 1'b0},
		'{FORM_SIMM, 6'd15, 10'd0, 1'b0, 1'b0, 1'b0},
		'{FORM_XO2, 6'd31, 10'd234, 1'b0, 1'b0, 1'b0},
		'{FORM_XO2, 6'd31, 10'd234, 1'b0, 1'b1, 1'b0},
		'{FORM_XO2, 6'd31, 10'd234, 1'b1, 1'b0, 1'b0},
		'{FORM_XO2, 6'd31, 10'd234, 1'b1, 1'b1, 1'b0},
		'{FORM_XO2, 6'd31, 10'd202, 1'b0, 1'b0, 1'b0},
		'{FORM_XO2, 6'd31, 10'd202, 1'b0, 1'b1, 1'b0},
		'{FORM_XO2, 6'd31, 10'd202, 1'b1, 1'b0, 1'b0},
		'{FORM_XO2, 6'd31, 10'd202, 1'b1, 1'b1, 1'b0},
		'{FORM_SWAP3, 6'd31, 10'd28, 1'b0, 1'b0, 1'b0},
		'{FORM_SWAP3, 6'd31, 10'd28, 1'b0, 1'b1, 1'b0},
		'{FORM_SWAP3, 6'd31, 10'd60, 1'b0, 1'b0, 1'b0},
		'{FORM_SWAP3, 6'd31, 10'd60, 1'b0, 1'b1, 1'b0},
		'{FORM_UIMM, 6'd28, 10'd0, 1'b0, 1'b0, 1'b0},
		'{FORM_UIMM, 6'd29, 10'd0, 1'b0, 1'b0, 1'b0},
		'{FORM_BLONG, 6'd18, 10'd0, 1'b0, 1'b0, 1'b0},
		'{FORM_BLONG, 6'd18, 10'd0, 1'b0, 1'b0, 1'b1},
		'{FORM_BLONG, 6'd18, 10'd0, 1'b0, 1'b1, 1'b0},
		'{FORM_BLONG, 6'd18, 10'd0, 1'b0, 1'b1, 1'b1},
		'{FORM_BSHORT, 6'd16, 10'd0, 1'b0, 1'b0, 1'b0},
		'{FORM_BSHORT, 6'd16, 10'd0, 1'b0, 1'b0, 1'b1},
		'{FORM_BSHORT, 6'd16, 10'd0, 1'b0, 1'b1, 1'b0},
		'{FORM_BSHORT, 6'd16, 10'd0, 1'b0, 1'b1, 1'b1},
		'{FORM_BREG, 6'd19, 10'd528, 1'b0, 1'b0, 1'b0},
		'{FORM_BREG, 6'd19, 10'd528, 1'b0, 1'b1, 1'b0},
		'{FORM_BREG, 6'd19, 10'd16, 1'b0, 1'b0, 1'b0},
		'{FORM_BREG, 6'd19, 10'd16, 1'b0, 1'b1, 1'b0}
	};

endpackage

// ----- design/ppcenc_front.sv -----
// Front end: accepts a request, looks up its mnemonic and checks operand kinds
// and alignment, and forms the branch displacement. Depends on ppcenc_pkg.
module ppcenc_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ppcenc_pkg::in_item_t  in_item,
	input  ppcenc_pkg::q_status_t q_status,
	output logic                  push,
	output ppcenc_pkg::cls_item_t cls
);

	logic                   cmd_ok;
	logic                   kind_ok;
	logic                   is_branch;
	ppcenc_pkg::enc_entry_t entry;
	logic                   k0_reg, k1_reg, k2_reg, k0_num, k1_num;

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	assign cmd_ok = in_item.command < 6'(ppcenc_pkg::CMD_COUNT);
	assign entry  = cmd_ok ? ppcenc_pkg::ENC_TABLE[in_item.command] : '0;

	assign k0_reg = in_item.kind_first == ppcenc_pkg::KIND_REG;
	assign k1_reg = in_item.kind_second == ppcenc_pkg::KIND_REG;
	assign k2_reg = in_item.kind_third == ppcenc_pkg::KIND_REG;
	assign k0_num = in_item.kind_first == ppcenc_pkg::KIND_NUM;
	assign k1_num = in_item.kind_second == ppcenc_pkg::KIND_NUM;

	always_comb begin
		case (entry.form)
			ppcenc_pkg::FORM_XO3:    kind_ok = k0_reg && k1_reg && k2_reg;
			ppcenc_pkg::FORM_XO2:    kind_ok = k0_reg && k1_reg;
			ppcenc_pkg::FORM_SWAP3:  kind_ok = k0_reg && k1_reg && k2_reg;
			ppcenc_pkg::FORM_SIMM:   kind_ok = k0_reg && k1_reg &&
				in_item.kind_third == ppcenc_pkg::KIND_SIMM;
			ppcenc_pkg::FORM_UIMM:   kind_ok = k0_reg && k1_reg &&
				in_item.kind_third == ppcenc_pkg::KIND_UIMM;
			ppcenc_pkg::FORM_BLONG:  kind_ok = in_item.kind_first == ppcenc_pkg::KIND_ADDR;
			ppcenc_pkg::FORM_BSHORT: kind_ok = k0_num && k1_num &&
				in_item.kind_third == ppcenc_pkg::KIND_ADDR;
			ppcenc_pkg::FORM_BREG:   kind_ok = k0_num && k1_num;
			default:                 kind_ok = 1'b0;
		endcase
	end

	assign is_branch = entry.form == ppcenc_pkg::FORM_BLONG ||
		entry.form == ppcenc_pkg::FORM_BSHORT;

	always_comb begin
		cls.entry = entry;
		cls.f0    = in_item.field_first;
		cls.f1    = in_item.field_second;
		cls.f2    = in_item.field_third;
		cls.imm   = in_item.imm_value;
		// absolute branches carry the target itself
		cls.diff  = entry.aa ? in_item.imm_value :
			in_item.imm_value - in_item.cur_address;
		if (!cmd_ok || !kind_ok) begin
			cls.err = ppcenc_pkg::ERR_BAD_KIND;
		end else if (is_branch && in_item.cur_address[1:0] != 2'b00) begin
			cls.err = ppcenc_pkg::ERR_PC_ALIGN;
		end else if (is_branch && in_item.imm_value[1:0] != 2'b00) begin
			cls.err = ppcenc_pkg::ERR_TARGET_ALIGN;
		end else begin
			cls.err = ppcenc_pkg::ERR_NONE;
		end
	end

endmodule

// ----- design/ppcenc_queue.sv -----
// Short request queue between the front and back ends.
// Depends on ppcenc_pkg and the shared assertion macros.
`include "ppc_instruction_encoder_unit_defines.svh"

module ppcenc_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ppcenc_pkg::cls_item_t push_item,
	input  logic                  pop,
	output ppcenc_pkg::cls_item_t head_item,
	output ppcenc_pkg::q_status_t q_status
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ppcenc_pkg::cls_item_t mem_q [DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [CW-1:0]         count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign head_item           = mem_q[rd_ptr_q];
	assign q_status.full       = count_q == CW'(DEPTH);
	assign q_status.head_valid = count_q != '0;

	`PPCENC_ASSERT_NOW(a_no_push_full, clk, arst_n, q_status.full, !push)
	`PPCENC_ASSERT_NOW(a_no_pop_empty, clk, arst_n, !q_status.head_valid, !pop)
	`PPCENC_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && !push,
		count_q == $past(count_q) - 1'b1)

endmodule

// ----- design/ppcenc_back.sv -----
// Back end: finishes range checks, assembles the instruction word and holds
// it in the output register. Depends on ppcenc_pkg and the assertion macros.
`include "ppc_instruction_encoder_unit_defines.svh"

module ppcenc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ppcenc_pkg::cls_item_t head_item,
	input  ppcenc_pkg::q_status_t q_status,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ppcenc_pkg::out_item_t out_item
);

	ppcenc_pkg::cls_item_t  c;
	ppcenc_pkg::err_t       err;
	ppcenc_pkg::err_t       reach_err;
	logic [31:0]            word;
	logic                   long_ok, short_ok;
	logic                   out_valid_q;
	ppcenc_pkg::out_item_t  out_q;

	assign c = head_item;

	// displacement fits when its upper bits are a pure sign extension
	assign long_ok   = (&c.diff[31:25]) || !(|c.diff[31:25]);
	assign short_ok  = (&c.diff[31:15]) || !(|c.diff[31:15]);
	assign reach_err = c.entry.aa ? ppcenc_pkg::ERR_BAD_ABSOLUTE :
		ppcenc_pkg::ERR_BRANCH_RANGE;

	always_comb begin
		word = {c.entry.primary, 26'd0};
		err  = c.err;
		case (c.entry.form)
			ppcenc_pkg::FORM_XO3: begin
				word[25:0] = {c.f0, c.f1, c.f2, c.entry.oe, c.entry.ext[8:0], c.entry.rclk};
			end
			ppcenc_pkg::FORM_XO2: begin
				word[25:0] = {c.f0, c.f1, 5'd0, c.entry.oe, c.entry.ext[8:0], c.entry.rclk};
			end
			ppcenc_pkg::FORM_SWAP3: begin
				word[25:0] = {c.f1, c.f0, c.f2, c.entry.ext, c.entry.rclk};
			end
			ppcenc_pkg::FORM_SIMM: begin
				word[25:0] = {c.f0, c.f1, c.imm[15:0]};
			end
			ppcenc_pkg::FORM_UIMM: begin
				word[25:0] = {c.f1, c.f0, c.imm[15:0]};
				if (err == ppcenc_pkg::ERR_NONE && c.imm[31:16] != 16'd0) begin
					err = ppcenc_pkg::ERR_VALUE_RANGE;
				end
			end
			ppcenc_pkg::FORM_BLONG: begin
				word[25:0] = {c.diff[25:2], c.entry.aa, c.entry.rclk};
				if (err == ppcenc_pkg::ERR_NONE && !long_ok) begin
					err = reach_err;
				end
			end
			ppcenc_pkg::FORM_BSHORT: begin
				word[25:0] = {c.f0, c.f1, c.diff[15:2], c.entry.aa, c.entry.rclk};
				if (err == ppcenc_pkg::ERR_NONE && !short_ok) begin
					err = reach_err;
				end
			end
			ppcenc_pkg::FORM_BREG: begin
				word[25:0] = {c.f0, c.f1, 5'd0, c.entry.ext, c.entry.rclk};
			end
			default: begin
				word = '0;
			end
		endcase
	end

	// advance whenever the output register is free or being drained
	assign pop = q_status.head_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.instr_word <= (err == ppcenc_pkg::ERR_NONE) ? word : 32'd0;
			out_q.error_code <= 3'(err);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`PPCENC_ASSERT_NOW(a_err_zero_word, clk, arst_n,
		out_valid_q && out_q.error_code != 3'(ppcenc_pkg::ERR_NONE), out_q.instr_word == 32'd0)
	`PPCENC_ASSERT_NEXT(a_pop_fills, clk, arst_n, pop, out_valid_q)
	`PPCENC_ASSERT_NOW(a_no_bubble, clk, arst_n, q_status.head_valid && !out_valid_q, pop)

endmodule

// ----- design/ppc_instruction_encoder_unit.sv -----
// Top level of the instruction encoder: front end, request queue, back end.
// Depends on ppcenc_pkg, ppcenc_front, ppcenc_queue and ppcenc_back.
//
//   channel | handshake             | payload
//   in      | in_valid / in_ready   | in_item  (ppcenc_pkg::in_item_t)
//   out     | out_valid / out_ready | out_item (ppcenc_pkg::out_item_t)
//
// One request per cycle sustained while out_ready stays high; a taken request
// is written into the queue and then loaded into the output register, which
// presents the result; a stalled output can keep it waiting in the queue.
// The queue holds QUEUE_DEPTH requests; in_ready drops only when it is full.
// Reset empties the queue and clears out_valid; queue storage and the output word are not reset.
// A stalled output holds its result while the queue fills behind it.
module ppc_instruction_encoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ppcenc_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ppcenc_pkg::out_item_t out_item
);

	logic                  push;
	logic                  pop;
	ppcenc_pkg::cls_item_t cls;
	ppcenc_pkg::cls_item_t head_item;
	ppcenc_pkg::q_status_t q_status;

	ppcenc_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_status (q_status),
		.push     (push),
		.cls      (cls)
	);

	ppcenc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (cls),
		.pop       (pop),
		.head_item (head_item),
		.q_status  (q_status)
	);

	ppcenc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ----- sim/tb.sv -----
// Testbench for ppc_instruction_encoder_unit: drives encode requests and checks each
// result against a predictor of the encoding rules. Needs ppcenc_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [5:0] {
		MN_ADD, MN_ADD_RC, MN_ADDO, MN_ADDO_RC,
		MN_ADDC, MN_ADDC_RC, MN_ADDCO, MN_ADDCO_RC,
		MN_ADDE, MN_ADDE_RC, MN_ADDEO, MN_ADDEO_RC,
		MN_ADDI, MN_ADDIC, MN_ADDIC_RC, MN_ADDIS,
		MN_ADDME, MN_ADDME_RC, MN_ADDMEO, MN_ADDMEO_RC,
		MN_ADDZE, MN_ADDZE_RC, MN_ADDZEO, MN_ADDZEO_RC,
		MN_AND, MN_AND_RC, MN_ANDC, MN_ANDC_RC,
		MN_ANDI_RC, MN_ANDIS_RC,
		MN_B, MN_BA, MN_BL, MN_BLA,
		MN_BC, MN_BCA, MN_BCL, MN_BCLA,
		MN_BCCTR, MN_BCCTRL, MN_BCLR, MN_BCLRL
	} mnemonic_t;

	localparam logic [2:0] KIND_UNDEF_LO = 3'd6;
	localparam logic [2:0] KIND_UNDEF_HI = 3'd7;

	localparam logic [5:0] OP_X31      = 6'd31;
	localparam logic [5:0] OP_XL19     = 6'd19;
	localparam logic [5:0] OP_ADDI     = 6'd14;
	localparam logic [5:0] OP_ADDIC    = 6'd12;
	localparam logic [5:0] OP_ADDIC_RC = 6'd13;
	localparam logic [5:0] OP_ADDIS    = 6'd15;
	localparam logic [5:0] OP_ANDI_RC  = 6'd28;
	localparam logic [5:0] OP_ANDIS_RC = 6'd29;
	localparam logic [5:0] OP_B        = 6'd18;
	localparam logic [5:0] OP_BC       = 6'd16;

	localparam logic [9:0] XO_ADD   = 10'd266;
	localparam logic [9:0] XO_ADDC  = 10'd10;
	localparam logic [9:0] XO_ADDE  = 10'd138;
	localparam logic [9:0] XO_ADDME = 10'd234;
	localparam logic [9:0] XO_ADDZE = 10'd202;
	localparam logic [9:0] XO_AND   = 10'd28;
	localparam logic [9:0] XO_ANDC  = 10'd60;
	localparam logic [9:0] XO_BCCTR = 10'd528;
	localparam logic [9:0] XO_BCLR  = 10'd16;

	localparam logic [31:0] OE_BIT          = 32'h0000_0400;
	localparam logic [31:0] UIMM_MAX        = 32'h0000_FFFF;
	localparam logic [31:0] LONG_HI_MASK    = 32'hFE00_0000;
	localparam logic [31:0] LONG_REACH      = 32'h0200_0000;
	localparam logic [31:0] LONG_DISP_MASK  = 32'h03FF_FFFC;
	localparam logic [31:0] SHORT_HI_MASK   = 32'hFFFF_8000;
	localparam logic [31:0] SHORT_REACH     = 32'h0000_8000;
	localparam logic [31:0] SHORT_DISP_MASK = 32'h0000_FFFC;

	typedef struct packed {
		ppcenc_pkg::form_t form;
		logic [5:0]        primary;
		logic [9:0]        xo;
		logic              oe;
		logic              lk;
		logic              aa;
	} mnemonic_info_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	ppcenc_pkg::in_item_t  in_item;
	logic                  out_valid;
	logic                  out_ready;
	ppcenc_pkg::out_item_t out_item;

	ppcenc_pkg::out_item_t pending_words[$];
	int                    fail_count;
	bit                    pacing_on;

	ppc_instruction_encoder_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

	function automatic mnemonic_info_t decode_mnemonic(logic [5:0] cmd);
		mnemonic_info_t d;
		logic [5:0]     idx;
		d = '0;
		d.form = ppcenc_pkg::FORM_XO3;
		d.primary = OP_X31;
		// in the register forms the two low mnemonic bits are OE and the record bit
		if (cmd <= MN_ADDEO_RC) begin
			d.xo = (cmd <= MN_ADDO_RC) ? XO_ADD : (cmd <= MN_ADDCO_RC) ? XO_ADDC : XO_ADDE;
			d.oe = cmd[1];
			d.lk = cmd[0];
		end else if (cmd <= MN_ADDIS) begin
			d.form = ppcenc_pkg::FORM_SIMM;
			case (cmd)
				MN_ADDI: d.primary = OP_ADDI;
				MN_ADDIC: d.primary = OP_ADDIC;
				MN_ADDIC_RC: d.primary = OP_ADDIC_RC;
				default: d.primary = OP_ADDIS;
			endcase
		end else if (cmd <= MN_ADDZEO_RC) begin
			d.form = ppcenc_pkg::FORM_XO2;
			d.xo = (cmd <= MN_ADDMEO_RC) ? XO_ADDME : XO_ADDZE;
			d.oe = cmd[1];
			d.lk = cmd[0];
		end else if (cmd <= MN_ANDC_RC) begin
			d.form = ppcenc_pkg::FORM_SWAP3;
			d.xo = (cmd <= MN_AND_RC) ? XO_AND : XO_ANDC;
			d.lk = cmd[0];
		end else if (cmd <= MN_ANDIS_RC) begin
			d.form = ppcenc_pkg::FORM_UIMM;
			d.primary = (cmd == MN_ANDI_RC) ? OP_ANDI_RC : OP_ANDIS_RC;
		end else if (cmd <= MN_BLA) begin
			idx = cmd - MN_B;
			d.form = ppcenc_pkg::FORM_BLONG;
			d.primary = OP_B;
			d.aa = idx[0];
			d.lk = idx[1];
		end else if (cmd <= MN_BCLA) begin
			idx = cmd - MN_BC;
			d.form = ppcenc_pkg::FORM_BSHORT;
			d.primary = OP_BC;
			d.aa = idx[0];
			d.lk = idx[1];
		end else begin
			d.form = ppcenc_pkg::FORM_BREG;
			d.primary = OP_XL19;
			d.xo = (cmd <= MN_BCCTRL) ? XO_BCCTR : XO_BCLR;
			d.lk = cmd[0];
		end
		return d;
	endfunction

	function automatic ppcenc_pkg::out_item_t encode_instruction(ppcenc_pkg::in_item_t r);
		mnemonic_info_t        d;
		logic [31:0]           w, ra, rb, rc, diff, hi, hi_mask;
		logic                  long_form;
		ppcenc_pkg::err_t      err;
		ppcenc_pkg::out_item_t res;
		d = decode_mnemonic(r.command);
		ra = 32'(r.field_first);
		rb = 32'(r.field_second);
		rc = 32'(r.field_third);
		w = {d.primary, 26'd0};
		err = ppcenc_pkg::ERR_NONE;
		if (r.command >= ppcenc_pkg::CMD_COUNT) begin
			err = ppcenc_pkg::ERR_BAD_KIND;
		end else begin
			case (d.form)
				ppcenc_pkg::FORM_XO3, ppcenc_pkg::FORM_XO2: begin
					if (r.kind_first != ppcenc_pkg::KIND_REG ||
					    r.kind_second != ppcenc_pkg::KIND_REG ||
					    (d.form == ppcenc_pkg::FORM_XO3 &&
					     r.kind_third != ppcenc_pkg::KIND_REG))
						err = ppcenc_pkg::ERR_BAD_KIND;
					w |= (ra << 21) | (rb << 16) | (32'(d.xo) << 1) | 32'(d.lk);
					if (d.form == ppcenc_pkg::FORM_XO3)
						w |= rc << 11;
					if (d.oe)
						w |= OE_BIT;
				end
				ppcenc_pkg::FORM_SWAP3: begin
					if (r.kind_first != ppcenc_pkg::KIND_REG ||
					    r.kind_second != ppcenc_pkg::KIND_REG ||
					    r.kind_third != ppcenc_pkg::KIND_REG)
						err = ppcenc_pkg::ERR_BAD_KIND;
					w |= (rb << 21) | (ra << 16) | (rc << 11) | (32'(d.xo) << 1) | 32'(d.lk);
				end
				ppcenc_pkg::FORM_SIMM: begin
					if (r.kind_first != ppcenc_pkg::KIND_REG ||
					    r.kind_second != ppcenc_pkg::KIND_REG ||
					    r.kind_third != ppcenc_pkg::KIND_SIMM)
						err = ppcenc_pkg::ERR_BAD_KIND;
					w |= (ra << 21) | (rb << 16) | {16'd0, r.imm_value[15:0]};
				end
				ppcenc_pkg::FORM_UIMM: begin
					if (r.kind_first != ppcenc_pkg::KIND_REG ||
					    r.kind_second != ppcenc_pkg::KIND_REG ||
					    r.kind_third != ppcenc_pkg::KIND_UIMM)
						err = ppcenc_pkg::ERR_BAD_KIND;
					else if (r.imm_value > UIMM_MAX)
						err = ppcenc_pkg::ERR_VALUE_RANGE;
					w |= (rb << 21) | (ra << 16) | r.imm_value;
				end
				ppcenc_pkg::FORM_BLONG, ppcenc_pkg::FORM_BSHORT: begin
					long_form = (d.form == ppcenc_pkg::FORM_BLONG);
					hi_mask = long_form ? LONG_HI_MASK : SHORT_HI_MASK;
					diff = r.imm_value - r.cur_address;
					if (long_form ? (r.kind_first != ppcenc_pkg::KIND_ADDR) :
					    (r.kind_first != ppcenc_pkg::KIND_NUM ||
					     r.kind_second != ppcenc_pkg::KIND_NUM ||
					     r.kind_third != ppcenc_pkg::KIND_ADDR)) begin
						err = ppcenc_pkg::ERR_BAD_KIND;
					end else if (r.cur_address[1:0] != 2'b00) begin
						err = ppcenc_pkg::ERR_PC_ALIGN;
					end else if (r.imm_value[1:0] != 2'b00) begin
						err = ppcenc_pkg::ERR_TARGET_ALIGN;
					end else if (d.aa) begin
						hi = r.imm_value & hi_mask;
						if (hi != hi_mask && hi != '0)
							err = ppcenc_pkg::ERR_BAD_ABSOLUTE;
						diff = r.imm_value;
					end else if (diff >= (~hi_mask + 32'd1) && diff < hi_mask) begin
						err = ppcenc_pkg::ERR_BRANCH_RANGE;
					end
					if (long_form)
						w |= diff & LONG_DISP_MASK;
					else
						w |= (ra << 21) | (rb << 16) | (diff & SHORT_DISP_MASK);
					w |= {30'd0, d.aa, d.lk};
				end
				default: begin
					if (r.kind_first != ppcenc_pkg::KIND_NUM ||
					    r.kind_second != ppcenc_pkg::KIND_NUM)
						err = ppcenc_pkg::ERR_BAD_KIND;
					w |= (ra << 21) | (rb << 16) | (32'(d.xo) << 1) | 32'(d.lk);
				end
			endcase
		end
		res.instr_word = (err == ppcenc_pkg::ERR_NONE) ? w : '0;
		res.error_code = 3'(err);
		return res;
	endfunction

	// well-formed operands for the mnemonic, branch targets within reach
	function automatic ppcenc_pkg::in_item_t make_request(logic [5:0] cmd);
		ppcenc_pkg::in_item_t r;
		mnemonic_info_t       d;
		logic [31:0]          o, off;
		logic                 long_form;
		d = decode_mnemonic(cmd);
		r.command = cmd;
		r.kind_first = ppcenc_pkg::KIND_REG;
		r.kind_second = ppcenc_pkg::KIND_REG;
		r.kind_third = 3'($urandom_range(0, 7));
		r.field_first = 5'($urandom);
		r.field_second = 5'($urandom);
		r.field_third = 5'($urandom);
		r.imm_value = $urandom;
		r.cur_address = $urandom;
		case (d.form)
			ppcenc_pkg::FORM_XO3, ppcenc_pkg::FORM_SWAP3: r.kind_third = ppcenc_pkg::KIND_REG;
			ppcenc_pkg::FORM_XO2: ;
			ppcenc_pkg::FORM_SIMM: r.kind_third = ppcenc_pkg::KIND_SIMM;
			ppcenc_pkg::FORM_UIMM: begin
				r.kind_third = ppcenc_pkg::KIND_UIMM;
				r.imm_value = $urandom_range(0, UIMM_MAX);
			end
			ppcenc_pkg::FORM_BREG: begin
				r.kind_first = ppcenc_pkg::KIND_NUM;
				r.kind_second = ppcenc_pkg::KIND_NUM;
			end
			default: begin
				long_form = (d.form == ppcenc_pkg::FORM_BLONG);
				if (long_form) begin
					r.kind_first = ppcenc_pkg::KIND_ADDR;
					r.kind_second = 3'($urandom_range(0, 7));
				end else begin
					r.kind_first = ppcenc_pkg::KIND_NUM;
					r.kind_second = ppcenc_pkg::KIND_NUM;
					r.kind_third = ppcenc_pkg::KIND_ADDR;
				end
				r.cur_address[1:0] = 2'b00;
				o = $urandom;
				off = long_form ? {{6{o[25]}}, o[25:0]} : {{16{o[15]}}, o[15:0]};
				case ($urandom_range(0, 7))
					0: off = long_form ? ~LONG_HI_MASK : ~SHORT_HI_MASK;
					1: off = long_form ? LONG_HI_MASK : SHORT_HI_MASK;
					default: ;
				endcase
				off[1:0] = 2'b00;
				r.imm_value = d.aa ? off : r.cur_address + off;
			end
		endcase
		return r;
	endfunction

	// change one aspect of an otherwise well-formed request, which may spoil it
	function automatic ppcenc_pkg::in_item_t break_request(ppcenc_pkg::in_item_t r);
		case ($urandom_range(0, 5))
			0: r.kind_first = 3'($urandom_range(0, 7));
			1: r.kind_third = 3'($urandom_range(0, 7));
			2: r.cur_address[1:0] = 2'($urandom_range(1, 3));
			3: r.imm_value[1:0] = 2'($urandom_range(1, 3));
			4: r.imm_value[31:24] ^= 8'($urandom_range(1, 255));
			default: r.command = 6'($urandom_range(ppcenc_pkg::CMD_COUNT, 63));
		endcase
		return r;
	endfunction

	function automatic ppcenc_pkg::in_item_t noise_request();
		ppcenc_pkg::in_item_t r;
		logic [95:0]          raw;
		raw = {$urandom, $urandom, $urandom};
		r = raw[$bits(ppcenc_pkg::in_item_t)-1:0];
		return r;
	endfunction

	task automatic send_request(input ppcenc_pkg::in_item_t req);
		int gap;
		gap = pacing_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		do @(posedge clk); while (!in_ready);
		pending_words.push_back(encode_instruction(req));
	endtask

	task automatic send_branch(input logic [5:0] cmd, input logic [31:0] pc, target);
		ppcenc_pkg::in_item_t req;
		req = make_request(cmd);
		req.cur_address = pc;
		req.imm_value = target;
		send_request(req);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	task automatic test_form_extremes();
		ppcenc_pkg::in_item_t req;
		req = make_request(MN_ADDCO_RC);
		{req.field_first, req.field_second, req.field_third} = '1;
		send_request(req);
		req = make_request(MN_ADDZEO_RC);
		{req.field_first, req.field_second, req.field_third} = '0;
		send_request(req);
		req = make_request(MN_ANDC_RC);
		{req.field_first, req.field_second, req.field_third} = {5'd31, 5'd0, 5'd31};
		send_request(req);
		req = make_request(MN_ADDIS);
		req.imm_value = '1;
		send_request(req);
		req = make_request(MN_ANDIS_RC);
		req.imm_value = UIMM_MAX;
		send_request(req);
		send_branch(MN_BLA, 32'h0000_0000, 32'hFFFF_FFFC);
		req = make_request(MN_BCLA);
		{req.field_first, req.field_second} = '1;
		req.imm_value = SHORT_HI_MASK;
		send_request(req);
		req = make_request(MN_BCLRL);
		{req.field_first, req.field_second} = '1;
		send_request(req);
	endtask

	task automatic test_special_cases();
		ppcenc_pkg::in_item_t req;
		logic [31:0]          pc;
		req = make_request(MN_ADD);
		req.command = 6'(ppcenc_pkg::CMD_COUNT);
		send_request(req);
		req.command = '1;
		send_request(req);
		req = make_request(MN_ADD);
		req.kind_second = KIND_UNDEF_HI;
		send_request(req);
		req = make_request(MN_BL);
		req.kind_first = KIND_UNDEF_LO;
		send_request(req);
		// third operand unused by the register branch: a bad kind there is ignored
		req = make_request(MN_BCCTR);
		req.kind_third = KIND_UNDEF_HI;
		send_request(req);
		req = make_request(MN_ANDI_RC);
		req.imm_value = UIMM_MAX + 32'd1;
		send_request(req);
		send_branch(MN_B, 32'h0000_1002, 32'h0000_2000);
		send_branch(MN_BC, 32'h0000_1000, 32'h0000_1001);
		send_branch(MN_BA, 32'h0000_1000, LONG_HI_MASK);
		send_branch(MN_BLA, 32'h0000_1000, LONG_REACH);
		send_branch(MN_BCA, 32'h0000_1000, SHORT_REACH);
		pc = 32'h4000_0000;
		send_branch(MN_B, pc, pc + ~LONG_HI_MASK - 32'd3);
		send_branch(MN_BL, pc, pc + LONG_REACH);
		send_branch(MN_B, pc, pc - LONG_REACH);
		send_branch(MN_BC, pc, pc + ~SHORT_HI_MASK - 32'd3);
		send_branch(MN_BCL, pc, pc + SHORT_REACH);
		send_branch(MN_BC, pc, pc - SHORT_REACH);
		// displacement wraps across the top of the address space
		send_branch(MN_B, 32'hFFFF_FFFC, 32'h0000_0004);
	endtask

	task automatic test_every_mnemonic();
		for (int m = 0; m < ppcenc_pkg::CMD_COUNT; m++)
			send_request(make_request(6'(m)));
	endtask

	task automatic test_random_mix(input int count);
		ppcenc_pkg::in_item_t req;
		int                   pick;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				pacing_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 19);
			req = make_request(6'($urandom_range(0, ppcenc_pkg::CMD_COUNT - 1)));
			if (pick >= 18)
				req = noise_request();
			else if (pick >= 15)
				req = break_request(req);
			send_request(req);
		end
		pacing_on = 1'b1;
	endtask

	task automatic test_random_branches(input int count);
		ppcenc_pkg::in_item_t req;
		for (int i = 0; i < count; i++) begin
			req = make_request(6'($urandom_range(MN_B, MN_BCLA)));
			if ($urandom_range(0, 4) == 0)
				req = break_request(req);
			send_request(req);
		end
	endtask

	// result side: while pacing is on, random stall before each result, then hold ready until taken
	initial begin
		int                    stall;
		ppcenc_pkg::out_item_t want;
		out_ready <= 1'b0;
		forever begin
			stall = pacing_on ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_words.size() == 0) begin
				$error("result with no request outstanding: instr_word %h error_code %0d",
				       out_item.instr_word, out_item.error_code);
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				if (out_item.instr_word !== want.instr_word) begin
					$error("instr_word: expected %h, got %h", want.instr_word,
					       out_item.instr_word);
					fail_count++;
				end
				if (out_item.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
					       out_item.error_code);
					fail_count++;
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		pacing_on = 1'b1;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_form_extremes();
		test_special_cases();
		test_every_mnemonic();
		test_random_mix(300);
		wait_for_results();
		test_random_branches(200);
		test_random_mix(200);
		wait_for_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/ppcenc_pkg.sv
design/ppcenc_front.sv
design/ppcenc_queue.sv
design/ppcenc_back.sv
design/ppc_instruction_encoder_unit.sv
sim/tb.sv
